// File: sv/sdf_pkg.sv
// Package for the signed decimal formatter: payload types, character codes,
// register indexes and length mode codes. No dependencies.
package sdf_pkg;

  typedef logic signed [63:0] value_t;
  typedef logic [7:0]         char_t;

  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_PLUS  = 8'h2B;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_ZERO  = 8'h30;

  localparam int unsigned OutLimit = 63;
  localparam int unsigned CfgAddrW = 5;

  localparam logic [2:0] REG_FIELD_WIDTH   = 3'd0;
  localparam logic [2:0] REG_PAD_AFTER     = 3'd1;
  localparam logic [2:0] REG_PRECISION_SET = 3'd2;
  localparam logic [2:0] REG_PRECISION     = 3'd3;
  localparam logic [2:0] REG_PLUS_SIGN     = 3'd4;
  localparam logic [2:0] REG_SPACE_SIGN    = 3'd5;
  localparam logic [2:0] REG_ZERO_PAD      = 3'd6;
  localparam logic [2:0] REG_LENGTH_MODE   = 3'd7;

  localparam logic [1:0] LEN_INT   = 2'd0;
  localparam logic [1:0] LEN_SHORT = 2'd1;
  localparam logic [1:0] LEN_LONG  = 2'd2;

endpackage

// File: sv/sdf_if.sv
// Handshake channel interfaces for the signed decimal formatter.
// Depends on sdf_pkg for the payload types.
interface sdf_in_if;
  import sdf_pkg::*;
  logic   valid;
  logic   ready;
  value_t value;
  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface sdf_out_if;
  import sdf_pkg::*;
  logic  valid;
  logic  ready;
  char_t out_char;
  logic  last_char;
  modport source (output valid, output out_char, output last_char, input ready);
  modport sink (input valid, input out_char, input last_char, output ready);
endinterface

// File: sv/signed_decimal_formatter_top.sv
// Signed decimal formatter: turns one signed integer into printf-style text.
// Input channel in_i carries a 64-bit value; output channel out_o carries one
// ASCII character per item with last_char on the final one. Format options
// are set through an APB-style register port.
//
// Steps per value: a load, then the shift-and-adjust conversion of the
// binary-to-BCD unit over the 16, 32 or 64 bits chosen by length mode, then
// a scan down from the top digit for the leading digit (cut short when the
// digit store overflows), field sizing in ST_CALC1 and ST_CALC2, then one
// character per cycle while the receiver takes them. in_i.ready is high only
// while idle; the next value may be taken while the final character still
// waits in the output register. A value that yields no characters returns
// to idle silently. When out_o.ready is low, the current character is held
// and the emitter waits. Reset clears all format registers to zero and
// returns to idle. The register port is written with pready always high;
// reads return the register values.
module signed_decimal_formatter_top #(
  parameter int unsigned MAX_DIGITS = 20,
  parameter int unsigned MAX_WIDTH  = 63
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  sdf_in_if.sink                         in_i,
  sdf_out_if.source                      out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sdf_pkg::CfgAddrW-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import sdf_pkg::*;

  localparam int unsigned IdxW  = $clog2(MAX_DIGITS);
  localparam int unsigned NdigW = $clog2(MAX_DIGITS + 1);
  localparam logic [IdxW-1:0]  IdxTop  = IdxW'(MAX_DIGITS - 1);
  localparam logic [NdigW-1:0] NdigMax = NdigW'(MAX_DIGITS);
  localparam logic [5:0]       WidthMax = 6'(MAX_WIDTH);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CONV  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_CALC1 = 3'd3;
  localparam logic [2:0] ST_CALC2 = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  // Format registers.
  logic [5:0] field_width_q;
  logic       pad_after_q, precision_set_q, plus_sign_q, space_sign_q, zero_pad_q;
  logic [5:0] precision_q;
  logic [1:0] length_mode_q;

  logic       cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_width_q   <= '0;
      pad_after_q     <= 1'b0;
      precision_set_q <= 1'b0;
      precision_q     <= '0;
      plus_sign_q     <= 1'b0;
      space_sign_q    <= 1'b0;
      zero_pad_q      <= 1'b0;
      length_mode_q   <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_FIELD_WIDTH:   field_width_q   <= pwdata[5:0];
        REG_PAD_AFTER:     pad_after_q     <= pwdata[0];
        REG_PRECISION_SET: precision_set_q <= pwdata[0];
        REG_PRECISION:     precision_q     <= pwdata[5:0];
        REG_PLUS_SIGN:     plus_sign_q     <= pwdata[0];
        REG_SPACE_SIGN:    space_sign_q    <= pwdata[0];
        REG_ZERO_PAD:      zero_pad_q      <= pwdata[0];
        REG_LENGTH_MODE:   length_mode_q   <= pwdata[1:0];
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      REG_FIELD_WIDTH:   prdata[5:0] = field_width_q;
      REG_PAD_AFTER:     prdata[0]   = pad_after_q;
      REG_PRECISION_SET: prdata[0]   = precision_set_q;
      REG_PRECISION:     prdata[5:0] = precision_q;
      REG_PLUS_SIGN:     prdata[0]   = plus_sign_q;
      REG_SPACE_SIGN:    prdata[0]   = space_sign_q;
      REG_ZERO_PAD:      prdata[0]   = zero_pad_q;
      REG_LENGTH_MODE:   prdata[1:0] = length_mode_q;
    endcase
  end

  // Sequencer and datapath state.
  logic [2:0]       state_q, state_d;
  logic [6:0]       cnt_q, cnt_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [NdigW-1:0] ndig_q, ndig_d;
  logic             ovf_q, ovf_d;
  logic             neg_q, neg_d;
  logic             mag_zero_q, mag_zero_d;
  logic [5:0]       zeros_q, zeros_d;
  logic [NdigW-1:0] printed_q, printed_d;
  logic             signlen_q, signlen_d;
  char_t            signch_q, signch_d;
  logic             zmode_q, zmode_d;
  logic [6:0]       textlen_q, textlen_d;
  logic [7:0]       b1_q, b2_q, b4_q, b5_q;
  logic [7:0]       b1_d, b2_d, b4_d, b5_d;
  logic [5:0]       total_q, total_d;
  logic [5:0]       pos_q, pos_d;
  logic             out_valid_q, out_valid_d;

  // Payload registers.
  logic [63:0]      bin_q, bin_d;
  logic [3:0]       digits_q [MAX_DIGITS];
  logic [3:0]       digits_d [MAX_DIGITS];
  char_t            out_char_q, out_char_d;
  logic             out_last_q, out_last_d;

  // Binary-to-BCD step: add three to every digit of five or more, then shift.
  logic [3:0]       adj [MAX_DIGITS];
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      adj[i] = (digits_q[i] >= 4'd5) ? digits_q[i] + 4'd3 : digits_q[i];
    end
  end

  // Load-time magnitude.
  logic [63:0] sext;
  logic [63:0] mag;
  logic        in_neg;
  always_comb begin
    unique case (length_mode_q)
      LEN_SHORT: sext = {{48{in_i.value[15]}}, in_i.value[15:0]};
      LEN_LONG:  sext = in_i.value;
      default:   sext = {{32{in_i.value[31]}}, in_i.value[31:0]};
    endcase
    in_neg = sext[63];
    mag    = in_neg ? (64'd0 - sext) : sext;
  end

  // Sizing helpers.
  logic [5:0] prec;
  logic [5:0] width_sat;
  logic [5:0] pad;
  logic [7:0] sum_len;
  always_comb begin
    prec      = precision_set_q ? precision_q : 6'd1;
    width_sat = (field_width_q > WidthMax) ? WidthMax : field_width_q;
    // The text is shorter than 64 characters whenever it is padded.
    pad       = ({1'b0, width_sat} > textlen_q) ? (width_sat - textlen_q[5:0]) : 6'd0;
    sum_len   = {2'b0, pad} + {1'b0, textlen_q};
  end

  // Character at the current position.
  logic [7:0] pos8;
  logic       emit_load, emit_last, in_digits;
  char_t      next_char;
  always_comb begin
    pos8      = {2'b0, pos_q};
    in_digits = 1'b0;
    priority if (pos8 < b1_q) begin
      next_char = CH_SPACE;
    end else if (pos8 < b2_q) begin
      next_char = signch_q;
    end else if (pos8 < b4_q) begin
      next_char = CH_ZERO;
    end else if (pos8 < b5_q) begin
      next_char = CH_ZERO + {4'd0, digits_q[idx_q]};
      in_digits = 1'b1;
    end else begin
      next_char = CH_SPACE;
    end
    emit_load = (state_q == ST_EMIT) && (!out_valid_q || out_o.ready);
    emit_last = (pos_q == total_q - 6'd1);
  end

  assign in_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.out_char  = out_char_q;
  assign out_o.last_char = out_last_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    ndig_d      = ndig_q;
    ovf_d       = ovf_q;
    neg_d       = neg_q;
    mag_zero_d  = mag_zero_q;
    zeros_d     = zeros_q;
    printed_d   = printed_q;
    signlen_d   = signlen_q;
    signch_d    = signch_q;
    zmode_d     = zmode_q;
    textlen_d   = textlen_q;
    b1_d        = b1_q;
    b2_d        = b2_q;
    b4_d        = b4_q;
    b5_d        = b5_q;
    total_d     = total_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    bin_d       = bin_q;
    digits_d    = digits_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          neg_d      = in_neg;
          mag_zero_d = (sext == 64'd0);
          ovf_d      = 1'b0;
          pos_d      = '0;
          for (int i = 0; i < MAX_DIGITS; i++) begin
            digits_d[i] = 4'd0;
          end
          unique case (length_mode_q)
            LEN_SHORT: begin
              bin_d = {mag[15:0], 48'd0};
              cnt_d = 7'd16;
            end
            LEN_LONG: begin
              bin_d = mag;
              cnt_d = 7'd64;
            end
            default: begin
              bin_d = {mag[31:0], 32'd0};
              cnt_d = 7'd32;
            end
          endcase
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        digits_d[0] = {adj[0][2:0], bin_q[63]};
        for (int i = 1; i < MAX_DIGITS; i++) begin
          digits_d[i] = {adj[i][2:0], adj[i-1][3]};
        end
        // A bit carried out of the top digit means digits were dropped.
        ovf_d = ovf_q | adj[MAX_DIGITS-1][3];
        bin_d = {bin_q[62:0], 1'b0};
        cnt_d = cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          idx_d   = IdxTop;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (ovf_q) begin
          ndig_d  = NdigMax;
          state_d = ST_CALC1;
        end else if (digits_q[idx_q] != 4'd0 || idx_q == '0) begin
          ndig_d  = NdigW'(idx_q) + NdigW'(1);
          state_d = ST_CALC1;
        end else begin
          idx_d = idx_q - IdxW'(1);
        end
      end
      ST_CALC1: begin
        zeros_d   = ({1'b0, prec} > 7'(ndig_q)) ? (prec - 6'(ndig_q)) : 6'd0;
        printed_d = (mag_zero_q && prec == 6'd0) ? '0 : ndig_q;
        if (neg_q) begin
          signch_d  = CH_MINUS;
          signlen_d = 1'b1;
        end else if (plus_sign_q) begin
          signch_d  = CH_PLUS;
          signlen_d = 1'b1;
        end else if (space_sign_q) begin
          signch_d  = CH_SPACE;
          signlen_d = 1'b1;
        end else begin
          signch_d  = CH_SPACE;
          signlen_d = 1'b0;
        end
        zmode_d   = zero_pad_q && !precision_set_q && !pad_after_q;
        textlen_d = 7'(signlen_d) + 7'(zeros_d) + 7'(printed_d);
        state_d   = ST_CALC2;
      end
      ST_CALC2: begin
        b1_d    = (!pad_after_q && !zmode_q) ? {2'b0, pad} : 8'd0;
        b2_d    = b1_d + 8'(signlen_q);
        b4_d    = b2_d + (zmode_q ? {2'b0, pad} : 8'd0) + {2'b0, zeros_q};
        b5_d    = b4_d + 8'(printed_q);
        total_d = (sum_len > 8'(OutLimit)) ? 6'(OutLimit) : sum_len[5:0];
        state_d = (total_d == 6'd0) ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_load) begin
          out_valid_d = 1'b1;
          out_char_d  = next_char;
          out_last_d  = emit_last;
          pos_d       = pos_q + 6'd1;
          if (in_digits && idx_q != '0) begin
            idx_d = idx_q - IdxW'(1);
          end
          if (emit_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      ndig_q      <= '0;
      ovf_q       <= 1'b0;
      neg_q       <= 1'b0;
      mag_zero_q  <= 1'b0;
      zeros_q     <= '0;
      printed_q   <= '0;
      signlen_q   <= 1'b0;
      signch_q    <= CH_SPACE;
      zmode_q     <= 1'b0;
      textlen_q   <= '0;
      b1_q        <= '0;
      b2_q        <= '0;
      b4_q        <= '0;
      b5_q        <= '0;
      total_q     <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      ndig_q      <= ndig_d;
      ovf_q       <= ovf_d;
      neg_q       <= neg_d;
      mag_zero_q  <= mag_zero_d;
      zeros_q     <= zeros_d;
      printed_q   <= printed_d;
      signlen_q   <= signlen_d;
      signch_q    <= signch_d;
      zmode_q     <= zmode_d;
      textlen_q   <= textlen_d;
      b1_q        <= b1_d;
      b2_q        <= b2_d;
      b4_q        <= b4_d;
      b5_q        <= b5_d;
      total_q     <= total_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q      <= bin_d;
    digits_q   <= digits_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

`ifndef NO_ASSERTIONS
  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EMIT))
    else $error("output item appeared outside the emit phase");

  a_conv_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV) |-> (cnt_q != 7'd0))
    else $error("conversion running with an empty step count");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_load && emit_last) |=> (state_q == ST_IDLE && out_last_q))
    else $error("final character did not return the sequencer to idle");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (pos_q < total_q))
    else $error("emit position ran past the text length");
`endif

endmodule

// File: dv/signed_decimal_formatter_top_test.sv
// Self-checking testbench for signed_decimal_formatter_top: a directed table, then random
// values under changing format settings, checked against a local model of the formatter.
// Depends on sdf_pkg, the interfaces in sdf_if.sv and the top level.
module signed_decimal_formatter_top_test;
  import sdf_pkg::*;

  localparam int MaxDigits    = 20;
  localparam int MaxWidth     = 63;
  localparam int SettleCycles = 200;
  localparam int HoldCycles   = 400;
  localparam int CycleLimit   = 500000;

  typedef struct packed {
    logic [5:0] field_width;
    logic       pad_after;
    logic       precision_set;
    logic [5:0] precision;
    logic       plus_sign;
    logic       space_sign;
    logic       zero_pad;
    logic [1:0] length_mode;
  } fmt_cfg_t;

  typedef struct packed {
    char_t ch;
    logic  last;
  } exp_char_t;

  typedef struct {
    fmt_cfg_t cfg;
    value_t   value;
    bit       typed;
    string    txt;
  } table_row_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  sdf_in_if  in_ch();
  sdf_out_if out_ch();

  signed_decimal_formatter_top DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  fmt_cfg_t   fmt;
  exp_char_t  expected_chars[$];
  table_row_t directed_rows[$];
  char_t      text_buf[OutLimit];
  int         text_len;
  int         mismatches = 0;
  int         idle_pct = 0;
  int         stall_pct = 0;
  int         cycle_count = 0;
  logic       recv_hold = 1'b0;
  event       hold_start;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Receiver side: random stalls, plus a long hold-off on request.
  always @(posedge clk_i) begin
    out_ch.ready <= !recv_hold && ($urandom_range(99) >= stall_pct);
  end

  always begin
    @(hold_start);
    recv_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    recv_hold <= 1'b0;
  end

  always @(posedge clk_i) begin
    exp_char_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_chars.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected item: char %h last %b", out_ch.out_char, out_ch.last_char);
        mismatches++;
      end else begin
        want = expected_chars.pop_front();
        if (want.ch !== out_ch.out_char || want.last !== out_ch.last_char) begin
          if (mismatches < 10)
            $display("wrong item: char %h (want %h) last %b (want %b)",
                     out_ch.out_char, want.ch, out_ch.last_char, want.last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("signed_decimal_formatter_top: mismatch");
    $finish;
  end

  function automatic void put_ch(input char_t ch);
    if (text_len < OutLimit) begin
      text_buf[text_len] = ch;
      text_len++;
    end
  endfunction

  // Builds the text of one value under the current settings and queues it.
  function automatic void predict_text(input value_t v);
    logic [63:0] raw, mag, t, rem;
    logic [3:0]  digits[MaxDigits];
    logic        neg;
    int          ndig, prec, zeros, printed, textlen, width, pad, k;
    char_t       sign_ch;
    bit          zero_mode;
    raw = v;
    case (fmt.length_mode)
      LEN_SHORT: begin
        neg = raw[15];
        mag = neg ? 64'h1_0000 - {48'd0, raw[15:0]} : {48'd0, raw[15:0]};
      end
      LEN_LONG: begin
        neg = raw[63];
        mag = neg ? -raw : raw;
      end
      default: begin
        neg = raw[31];
        mag = neg ? 64'h1_0000_0000 - {32'd0, raw[31:0]} : {32'd0, raw[31:0]};
      end
    endcase
    ndig = 0;
    t = mag;
    do begin
      rem = t % 64'd10;
      digits[ndig] = rem[3:0];
      t = t / 64'd10;
      ndig++;
    end while (t != 0 && ndig < MaxDigits);
    prec = fmt.precision_set ? int'(fmt.precision) : 1;
    zeros = (prec > ndig) ? prec - ndig : 0;
    printed = (mag == 0 && prec == 0) ? 0 : ndig;
    sign_ch = 8'h00;
    if (neg) sign_ch = CH_MINUS;
    else if (fmt.plus_sign) sign_ch = CH_PLUS;
    else if (fmt.space_sign) sign_ch = CH_SPACE;
    textlen = (sign_ch != 8'h00) + zeros + printed;
    width = (int'(fmt.field_width) > MaxWidth) ? MaxWidth : int'(fmt.field_width);
    pad = (width > textlen) ? width - textlen : 0;
    zero_mode = fmt.zero_pad && !fmt.precision_set && !fmt.pad_after;
    text_len = 0;
    if (!fmt.pad_after && !zero_mode)
      for (k = 0; k < pad; k++) put_ch(CH_SPACE);
    if (sign_ch != 8'h00) put_ch(sign_ch);
    if (zero_mode)
      for (k = 0; k < pad; k++) put_ch(CH_ZERO);
    for (k = 0; k < zeros; k++) put_ch(CH_ZERO);
    for (k = printed; k > 0; k--) put_ch(CH_ZERO + char_t'(digits[k-1]));
    if (fmt.pad_after)
      for (k = 0; k < pad; k++) put_ch(CH_SPACE);
    for (k = 0; k < text_len; k++)
      expected_chars.push_back('{ch: text_buf[k], last: (k == text_len - 1)});
  endfunction

  // Leaves the access edge with psel high so that back-to-back writes need
  // only one assignment per signal in each step.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
  endtask

  task automatic apply_cfg(input fmt_cfg_t c);
    write_reg(REG_FIELD_WIDTH, 32'(c.field_width));
    write_reg(REG_PAD_AFTER, 32'(c.pad_after));
    write_reg(REG_PRECISION_SET, 32'(c.precision_set));
    write_reg(REG_PRECISION, 32'(c.precision));
    write_reg(REG_PLUS_SIGN, 32'(c.plus_sign));
    write_reg(REG_SPACE_SIGN, 32'(c.space_sign));
    write_reg(REG_ZERO_PAD, 32'(c.zero_pad));
    write_reg(REG_LENGTH_MODE, 32'(c.length_mode));
    psel    <= 1'b0;
    penable <= 1'b0;
    fmt = c;
  endtask

  // A value that gives no text can still be in flight once the queue is
  // empty, so the settle wait covers the longest conversion.
  task automatic drain_outputs();
    in_ch.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic send_value(input value_t v, input bit typed, input string txt);
    int i;
    if ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    do @(posedge clk_i); while (!in_ch.ready);
    if (typed) begin
      for (i = 0; i < txt.len(); i++)
        expected_chars.push_back('{ch: char_t'(txt[i]), last: (i == txt.len() - 1)});
    end else begin
      predict_text(v);
    end
  endtask

  function automatic fmt_cfg_t mk_cfg(input int fw, input bit la, input bit ps, input int pr,
                                      input bit pl, input bit sp, input bit zp,
                                      input logic [1:0] lm);
    fmt_cfg_t c;
    c.field_width   = fw[5:0];
    c.pad_after     = la;
    c.precision_set = ps;
    c.precision     = pr[5:0];
    c.plus_sign     = pl;
    c.space_sign    = sp;
    c.zero_pad      = zp;
    c.length_mode   = lm;
    return c;
  endfunction

  function automatic fmt_cfg_t rand_cfg();
    fmt_cfg_t c;
    case ($urandom_range(3))
      0: c.field_width = 6'd0;
      1: c.field_width = 6'd63;
      default: c.field_width = 6'($urandom_range(20));
    endcase
    case ($urandom_range(3))
      0: c.precision = 6'd0;
      1: c.precision = 6'd63;
      default: c.precision = 6'($urandom_range(25));
    endcase
    c.pad_after     = 1'($urandom_range(1));
    c.precision_set = 1'($urandom_range(1));
    c.plus_sign     = 1'($urandom_range(1));
    c.space_sign    = 1'($urandom_range(1));
    c.zero_pad      = 1'($urandom_range(1));
    c.length_mode   = 2'($urandom_range(3));
    return c;
  endfunction

  function automatic value_t rand_value();
    logic [63:0] v;
    case ($urandom_range(5))
      0: begin
        v = 64'($urandom_range(999));
        if ($urandom_range(1)) v = -v;
      end
      1: begin
        case ($urandom_range(7))
          0: v = 64'h8000_0000_0000_0000;
          1: v = 64'h7FFF_FFFF_FFFF_FFFF;
          2: v = 64'hFFFF_FFFF_8000_0000;
          3: v = 64'h0000_0000_7FFF_FFFF;
          4: v = 64'h0000_0000_0000_8000;
          5: v = 64'h0000_0000_0000_7FFF;
          6: v = 64'd0;
          default: v = '1;
        endcase
      end
      2: begin
        // Powers of ten and their neighbors stress the digit count.
        v = 64'd1;
        repeat ($urandom_range(19)) v = v * 64'd10;
        v = v + 64'($urandom_range(2)) - 64'd1;
        if ($urandom_range(1)) v = -v;
      end
      default: v = {$urandom, $urandom};
    endcase
    return value_t'(v);
  endfunction

  task automatic add_row(input fmt_cfg_t c, input logic [63:0] v, input bit typed,
                         input string txt);
    table_row_t r;
    r.cfg   = c;
    r.value = value_t'(v);
    r.typed = typed;
    r.txt   = txt;
    directed_rows.push_back(r);
  endtask

  initial begin
    bit first;
    int phase, blk, n;
    fmt_cfg_t c;

    rst_ni       <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.value  <= '0;
    fmt = '0;

    //      width la ps prec pl sp zp length
    add_row(mk_cfg(0, 0, 0, 0, 0, 0, 0, LEN_INT), 64'd0, 1, "0");
    add_row(mk_cfg(0, 0, 0, 0, 0, 0, 0, LEN_INT), 64'd123, 1, "123");
    add_row(mk_cfg(0, 0, 0, 0, 0, 0, 0, LEN_INT), '1, 1, "-1");
    add_row(mk_cfg(0, 0, 0, 0, 0, 0, 0, LEN_INT), 64'h8000_0000, 1, "-2147483648");
    add_row(mk_cfg(0, 0, 0, 0, 0, 0, 0, LEN_INT), 64'h7FFF_FFFF, 1, "2147483647");
    add_row(mk_cfg(0, 0, 0, 0, 0, 0, 0, LEN_INT), 64'hFFFF_FFFF_0000_0005, 1, "5");
    add_row(mk_cfg(0, 0, 0, 0, 0, 0, 0, LEN_SHORT), 64'h8000, 1, "-32768");
    add_row(mk_cfg(0, 0, 0, 0, 0, 0, 0, LEN_SHORT), 64'h7FFF, 1, "32767");
    add_row(mk_cfg(0, 0, 0, 0, 0, 0, 0, LEN_SHORT), 64'h1234_5678_9ABC_FFFF, 1, "-1");
    add_row(mk_cfg(0, 0, 0, 0, 0, 0, 0, LEN_LONG), 64'h8000_0000_0000_0000, 1,
            "-9223372036854775808");
    add_row(mk_cfg(0, 0, 0, 0, 0, 0, 0, LEN_LONG), 64'h7FFF_FFFF_FFFF_FFFF, 1,
            "9223372036854775807");
    // Length mode 3 is unused and reads the value as 32 bits.
    add_row(mk_cfg(0, 0, 0, 0, 0, 0, 0, 2'd3), 64'hFFFF_FFFF_8000_0000, 1, "-2147483648");
    // Zero with zero precision prints no digits, possibly nothing at all.
    add_row(mk_cfg(0, 0, 1, 0, 0, 0, 0, LEN_INT), 64'd0, 1, "");
    add_row(mk_cfg(0, 0, 1, 0, 1, 0, 0, LEN_INT), 64'd0, 1, "+");
    add_row(mk_cfg(5, 0, 1, 0, 0, 0, 0, LEN_INT), 64'd0, 1, "     ");
    add_row(mk_cfg(0, 0, 0, 0, 1, 0, 0, LEN_INT), 64'd42, 1, "+42");
    add_row(mk_cfg(0, 0, 0, 0, 0, 1, 0, LEN_INT), 64'd42, 1, " 42");
    add_row(mk_cfg(0, 0, 0, 0, 1, 1, 0, LEN_INT), -64'd7, 1, "-7");
    add_row(mk_cfg(6, 0, 0, 0, 0, 0, 1, LEN_INT), -64'd42, 1, "-00042");
    add_row(mk_cfg(6, 1, 0, 0, 0, 0, 1, LEN_INT), -64'd42, 1, "-42   ");
    add_row(mk_cfg(6, 0, 1, 3, 0, 0, 1, LEN_INT), -64'd42, 1, "  -042");
    add_row(mk_cfg(10, 1, 0, 0, 0, 1, 0, LEN_INT), 64'd17, 1, " 17       ");
    add_row(mk_cfg(63, 0, 0, 0, 0, 0, 0, LEN_INT), 64'd1, 0, "");
    // Sign plus 44 zeros plus 19 digits is one character over the output limit.
    add_row(mk_cfg(0, 0, 1, 63, 1, 0, 0, LEN_LONG), 64'h8000_0000_0000_0000, 0, "");
    add_row(mk_cfg(63, 1, 0, 0, 1, 0, 0, LEN_LONG), 64'h7FFF_FFFF_FFFF_FFFF, 0, "");

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    first = 1'b1;
    foreach (directed_rows[i]) begin
      if (first || directed_rows[i].cfg != fmt) begin
        drain_outputs();
        apply_cfg(directed_rows[i].cfg);
        first = 1'b0;
      end
      send_value(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].txt);
    end

    for (phase = 0; phase < 4; phase++) begin
      drain_outputs();
      case (phase)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 73; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 73; end
        default: begin idle_pct = 29; stall_pct <= 29; end
      endcase
      for (blk = 0; blk < 4; blk++) begin
        drain_outputs();
        c = rand_cfg();
        apply_cfg(c);
        // Hold the receiver off while values keep coming so the input stalls.
        if (phase == 0 && blk == 1) -> hold_start;
        n = $urandom_range(11, 5);
        repeat (n) send_value(rand_value(), 0, "");
      end
    end

    drain_outputs();
    if (mismatches == 0) begin
      $display("signed_decimal_formatter_top: match");
    end else begin
      $display("signed_decimal_formatter_top: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/sdf_pkg.sv
sv/sdf_if.sv
sv/signed_decimal_formatter_top.sv
dv/signed_decimal_formatter_top_test.sv
